>>> rtl/core/rtps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_pkg
// Widths and constants shared by the run/pattern stream statistics block and
// its channel interfaces.
// ----------------------------------------------------------------------------
package rtps_pkg;

    localparam int unsigned SampleW  = 31;  // data value
    localparam int unsigned StartW   = 16;  // block-relative position
    localparam int unsigned LenW     = 17;  // run length
    localparam int unsigned TotalW   = 48;  // global saturating counters
    localparam int unsigned BlkTripW = 16;  // per-block triple counter
    localparam int unsigned BlkPatW  = 14;  // per-block pattern counter
    localparam int unsigned ProgW    = 3;   // pattern match progress

    // Longest block; the item at index MaxBlock-1 closes the block.
    localparam int unsigned MaxBlock = 65536;

    // Pattern is 0,1,2,...,PatternLen-1: element k equals k.
    localparam logic [ProgW-1:0] PatternLen = 3'd6;

endpackage

>>> rtl/core/rtps_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_item_if
// Input channel: one sample value and its end-of-block flag per transfer.
// ----------------------------------------------------------------------------
interface rtps_item_if;
    import rtps_pkg::*;

    logic               valid;
    logic               ready;
    logic [SampleW-1:0] sample_value;
    logic               block_end;

    modport source (output valid, output sample_value, output block_end, input ready);
    modport sink   (input valid, input sample_value, input block_end, output ready);

endinterface

>>> rtl/core/rtps_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_result_if
// Result channel: global longest run and saturating totals, one per block.
// ----------------------------------------------------------------------------
interface rtps_result_if;
    import rtps_pkg::*;

    logic               valid;
    logic               ready;
    logic [StartW-1:0]  best_run_start;
    logic [LenW-1:0]    best_run_length;
    logic [SampleW-1:0] best_run_value;
    logic [TotalW-1:0]  triple_total;
    logic [TotalW-1:0]  pattern_total;

    modport source (
        output valid, output best_run_start, output best_run_length,
        output best_run_value, output triple_total, output pattern_total,
        input  ready
    );
    modport sink (
        input  valid, input best_run_start, input best_run_length,
        input  best_run_value, input triple_total, input pattern_total,
        output ready
    );

endinterface

>>> rtl/core/run_triple_pattern_stream_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_triple_pattern_stream_stats
// Longest run of equal values, equal-triple count and 0..5 pattern count over
// a blocked value stream, merged into global totals at every block end.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                         per transfer
//  i_item     in   sample_value[30:0], block_end                   one value
//  o_result   out  best_run_start/length/value, triple/pattern_tot  one block end
//
//  Throughput: one value per cycle unless a block-closing value waits on a busy
//  result register; the limit is the single state update stage, which retires
//  one value each cycle. Result path: a block's last value passes the input
//  register, then the state update writes its result into the result register.
//  Reset: synchronous, active low; all statistics restart from zero.
//  Stalls: only a block-closing value waits for a busy result register; other
//  values keep flowing while a result sits untaken on o_result.
// ----------------------------------------------------------------------------
module run_triple_pattern_stream_stats (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtps_item_if.sink      i_item,
    rtps_result_if.source  o_result
);
    import rtps_pkg::*;

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [SampleW-1:0] r_in_value;
    logic               r_in_last;

    // ---------------- block state ----------------
    logic [SampleW-1:0]  r_prev;
    logic [LenW-1:0]     r_run_len;
    logic [1:0]          r_run_mod3;     // run length mod 3, tracked alongside
    logic [StartW-1:0]   r_run_start;
    logic [StartW-1:0]   r_index;
    logic [LenW-1:0]     r_bbest_len;
    logic [StartW-1:0]   r_bbest_start;
    logic [SampleW-1:0]  r_bbest_value;
    logic [BlkTripW-1:0] r_btrip;
    logic [ProgW-1:0]    r_prog;
    logic [BlkPatW-1:0]  r_bpat;

    // ---------------- global state ----------------
    logic [StartW-1:0]  r_gbest_start;
    logic [LenW-1:0]    r_gbest_len;
    logic [SampleW-1:0] r_gbest_value;
    logic [TotalW-1:0]  r_gtrip;
    logic [TotalW-1:0]  r_gpat;

    // ---------------- result register ----------------
    logic               r_out_valid;
    logic [StartW-1:0]  r_out_start;
    logic [LenW-1:0]    r_out_len;
    logic [SampleW-1:0] r_out_value;
    logic [TotalW-1:0]  r_out_trip;
    logic [TotalW-1:0]  r_out_pat;

    // ---------------- next values ----------------
    logic                forced_end;
    logic                blk_last;
    logic                out_free;
    logic                advance;
    logic                fire;
    logic                restart;
    logic                run_sat;
    logic [LenW-1:0]     n_run_len;
    logic [1:0]          n_run_mod3;
    logic [StartW-1:0]   n_run_start;
    logic [BlkTripW-1:0] n_btrip;
    logic                best_upd;
    logic [LenW-1:0]     n_bbest_len;
    logic [StartW-1:0]   n_bbest_start;
    logic [SampleW-1:0]  n_bbest_value;
    logic                pat_hit;
    logic [ProgW-1:0]    prog_inc;
    logic [ProgW-1:0]    n_prog;
    logic [BlkPatW-1:0]  n_bpat;
    logic                gbest_upd;
    logic [TotalW:0]     trip_sum;
    logic [TotalW:0]     pat_sum;
    logic [TotalW-1:0]   n_gtrip;
    logic [TotalW-1:0]   n_gpat;

    // Block closes on the flag or when the position reaches the block limit.
    assign forced_end = (32'(r_index) + 32'd1) >= 32'(MaxBlock);
    assign blk_last   = r_in_last || forced_end;
    assign out_free   = !r_out_valid || o_result.ready;
    // The held value moves on unless it closes a block and the result slot
    // is still occupied.
    assign advance    = !blk_last || out_free;
    assign fire       = r_in_valid && advance;

    assign i_item.ready = !r_in_valid || advance;

    // ---- run tracking ----
    always_comb begin
        restart     = (r_index == '0) || (r_run_len == '0) || (r_in_value != r_prev);
        run_sat     = (r_run_len == {LenW{1'b1}});
        n_run_len   = r_run_len;
        n_run_mod3  = r_run_mod3;
        n_run_start = r_run_start;
        if (restart) begin
            n_run_len   = LenW'(1);
            n_run_mod3  = 2'd1;
            n_run_start = r_index;
        end else if (!run_sat) begin
            n_run_len  = r_run_len + LenW'(1);
            n_run_mod3 = (r_run_mod3 == 2'd2) ? 2'd0 : r_run_mod3 + 2'd1;
        end

        // each third element of a run closes a non-overlapping triple
        n_btrip = r_btrip;
        if (n_run_mod3 == 2'd0 && r_btrip != {BlkTripW{1'b1}}) begin
            n_btrip = r_btrip + BlkTripW'(1);
        end

        // strictly longer only: earliest run keeps ties
        best_upd      = n_run_len > r_bbest_len;
        n_bbest_len   = best_upd ? n_run_len   : r_bbest_len;
        n_bbest_start = best_upd ? n_run_start : r_bbest_start;
        n_bbest_value = best_upd ? r_in_value  : r_bbest_value;
    end

    // ---- pattern 0,1,2,3,4,5 ----
    always_comb begin
        pat_hit  = (r_prog < PatternLen) && (r_in_value == SampleW'(r_prog));
        prog_inc = r_prog + ProgW'(1);
        n_bpat   = r_bpat;
        if (pat_hit) begin
            n_prog = prog_inc;
            if (prog_inc == PatternLen) begin
                n_prog = '0;
                if (r_bpat != {BlkPatW{1'b1}}) begin
                    n_bpat = r_bpat + BlkPatW'(1);
                end
            end
        end else begin
            // a mismatching zero starts a new match
            n_prog = (r_in_value == '0) ? ProgW'(1) : '0;
        end
    end

    // ---- merge into global totals ----
    always_comb begin
        gbest_upd = n_bbest_len > r_gbest_len;
        trip_sum  = {1'b0, r_gtrip} + (TotalW + 1)'(n_btrip);
        pat_sum   = {1'b0, r_gpat}  + (TotalW + 1)'(n_bpat);
        n_gtrip   = trip_sum[TotalW] ? {TotalW{1'b1}} : trip_sum[TotalW-1:0];
        n_gpat    = pat_sum[TotalW]  ? {TotalW{1'b1}} : pat_sum[TotalW-1:0];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_value <= i_item.sample_value;
            r_in_last  <= i_item.block_end;
        end
    end

    // block and global state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_run_len     <= '0;
            r_run_mod3    <= '0;
            r_run_start   <= '0;
            r_index       <= '0;
            r_bbest_len   <= '0;
            r_bbest_start <= '0;
            r_bbest_value <= '0;
            r_btrip       <= '0;
            r_prog        <= '0;
            r_bpat        <= '0;
            r_gbest_start <= '0;
            r_gbest_len   <= '0;
            r_gbest_value <= '0;
            r_gtrip       <= '0;
            r_gpat        <= '0;
        end else if (fire) begin
            r_prev <= r_in_value;
            if (!blk_last) begin
                r_run_len     <= n_run_len;
                r_run_mod3    <= n_run_mod3;
                r_run_start   <= n_run_start;
                r_index       <= r_index + StartW'(1);
                r_bbest_len   <= n_bbest_len;
                r_bbest_start <= n_bbest_start;
                r_bbest_value <= n_bbest_value;
                r_btrip       <= n_btrip;
                r_prog        <= n_prog;
                r_bpat        <= n_bpat;
            end else begin
                if (gbest_upd) begin
                    r_gbest_start <= n_bbest_start;
                    r_gbest_len   <= n_bbest_len;
                    r_gbest_value <= n_bbest_value;
                end
                r_gtrip       <= n_gtrip;
                r_gpat        <= n_gpat;
                // fresh block
                r_run_len     <= '0;
                r_run_mod3    <= '0;
                r_run_start   <= '0;
                r_index       <= '0;
                r_bbest_len   <= '0;
                r_bbest_start <= '0;
                r_bbest_value <= '0;
                r_btrip       <= '0;
                r_prog        <= '0;
                r_bpat        <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && blk_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && blk_last) begin
            r_out_start <= gbest_upd ? n_bbest_start : r_gbest_start;
            r_out_len   <= gbest_upd ? n_bbest_len   : r_gbest_len;
            r_out_value <= gbest_upd ? n_bbest_value : r_gbest_value;
            r_out_trip  <= n_gtrip;
            r_out_pat   <= n_gpat;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.best_run_start  = r_out_start;
    assign o_result.best_run_length = r_out_len;
    assign o_result.best_run_value  = r_out_value;
    assign o_result.triple_total    = r_out_trip;
    assign o_result.pattern_total   = r_out_pat;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for run_triple_pattern_stream_stats: directed and random
// value blocks go in, each block-end result is checked against a cycle-free
// model of the longest-run, triple and 0..5 pattern statistics.
// ----------------------------------------------------------------------------
module tb;
    import rtps_pkg::*;

    // Bench knobs.
    localparam int unsigned CycleLimit = 400_000;  // watchdog, far above a clean run
    localparam int unsigned HoldCycles = 300;      // long result back-pressure
    localparam int unsigned ReportMax  = 10;       // mismatches printed in full
    localparam int unsigned DrainWait  = 8;        // idle cycles after the last owed result

    // One block-end result: the global longest run and both totals.
    typedef struct packed {
        logic [StartW-1:0]  run_start;
        logic [LenW-1:0]    run_length;
        logic [SampleW-1:0] run_value;
        logic [TotalW-1:0]  triples;
        logic [TotalW-1:0]  patterns;
    } totals_t;

    // ------------------------------------------------------------------------
    // Running statistics of the value stream plus the queue of block totals
    // still owed by the block. note_value() advances the statistics for one
    // transferred value; check_totals() retires the oldest owed result.
    // ------------------------------------------------------------------------
    class block_stats_tracker;
        // per-block figures, cleared at every block end
        bit [SampleW-1:0]  prev_value;     // survives block ends
        bit [LenW-1:0]     run_len;
        bit [StartW-1:0]   run_start;
        bit [StartW-1:0]   position;
        bit [LenW-1:0]     blk_best_len;
        bit [StartW-1:0]   blk_best_start;
        bit [SampleW-1:0]  blk_best_value;
        bit [BlkTripW-1:0] blk_triples;
        bit [ProgW-1:0]    match_len;
        bit [BlkPatW-1:0]  blk_patterns;
        // global figures, what every result reports
        totals_t           running;
        totals_t           owed_totals[$];
        int unsigned       failures;
        int unsigned       blocks_closed;
        int unsigned       totals_checked;

        function automatic bit [TotalW-1:0] add_sat48(bit [TotalW-1:0] a,
                                                      bit [TotalW-1:0] b);
            bit [TotalW:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
        endfunction

        function void note_value(bit [SampleW-1:0] v, bit closes);
            bit block_done;
            block_done = closes;

            // runs restart at the block head or on a value change
            if (position == 0 || run_len == 0 || v != prev_value) begin
                run_start = position;
                run_len   = 1;
            end else if (run_len != {LenW{1'b1}}) begin
                run_len++;
            end
            if (run_len % 3 == 0 && blk_triples != {BlkTripW{1'b1}})
                blk_triples++;
            // strictly longer only: ties keep the earliest run
            if (run_len > blk_best_len) begin
                blk_best_len   = run_len;
                blk_best_start = run_start;
                blk_best_value = v;
            end

            // 0,1,2,3,4,5 matcher; a stray 0 restarts at one element matched
            if (match_len < PatternLen && v == SampleW'(match_len)) begin
                match_len++;
                if (match_len == PatternLen) begin
                    if (blk_patterns != {BlkPatW{1'b1}})
                        blk_patterns++;
                    match_len = 0;
                end
            end else begin
                match_len = (v == 0) ? ProgW'(1) : ProgW'(0);
            end

            prev_value = v;

            // the last slot of a maximum-size block closes it regardless
            if (32'(position) + 32'd1 >= MaxBlock)
                block_done = 1'b1;

            if (!block_done) begin
                position++;
                return;
            end

            if (blk_best_len > running.run_length) begin
                running.run_start  = blk_best_start;
                running.run_length = blk_best_len;
                running.run_value  = blk_best_value;
            end
            running.triples  = add_sat48(running.triples, TotalW'(blk_triples));
            running.patterns = add_sat48(running.patterns, TotalW'(blk_patterns));
            owed_totals.push_back(running);
            blocks_closed++;

            run_len        = 0;
            run_start      = 0;
            position       = 0;
            blk_best_len   = 0;
            blk_best_start = 0;
            blk_best_value = 0;
            blk_triples    = 0;
            match_len      = 0;
            blk_patterns   = 0;
        endfunction

        function void check_totals(totals_t got);
            totals_t want;
            if (owed_totals.size() == 0) begin
                failures++;
                if (failures <= ReportMax)
                    $display("[%0t] result with no block pending: start %0d len %0d",
                             $realtime, got.run_start, got.run_length);
                return;
            end
            want = owed_totals.pop_front();
            totals_checked++;
            if (got.run_start  !== want.run_start  ||
                got.run_length !== want.run_length ||
                got.run_value  !== want.run_value  ||
                got.triples    !== want.triples    ||
                got.patterns   !== want.patterns) begin
                failures++;
                if (failures <= ReportMax) begin
                    $display("[%0t] block %0d totals differ (expected / actual):",
                             $realtime, totals_checked);
                    $display("    start %0d / %0d  len %0d / %0d  value %h / %h",
                             want.run_start, got.run_start, want.run_length,
                             got.run_length, want.run_value, got.run_value);
                    $display("    triples %0d / %0d  patterns %0d / %0d",
                             want.triples, got.triples, want.patterns, got.patterns);
                end
            end
        endfunction

        function int unsigned owed();
            return owed_totals.size();
        endfunction

        // anything still owed at the end is a lost result
        function void close_out();
            failures += owed_totals.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, DUT
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    rtps_item_if   item_ch ();
    rtps_result_if result_ch ();

    run_triple_pattern_stream_stats i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    block_stats_tracker stats = new();

    int unsigned send_idle_pct = 23;   // only the sender process touches this
    int unsigned recv_idle_pct = 45;   // written by NBA, read at the edge
    logic        hold_results  = 1'b0; // long receiver hold-off request
    int unsigned values_sent   = 0;
    int unsigned cycle_count   = 0;

    // Everything the bench drives is known from time zero.
    initial begin
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.sample_value = '0;
        item_ch.block_end    = 1'b0;
        result_ch.ready      = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: check every result transfer, then pick ready for next cycle.
    // hold_results pins ready low for the back-pressure stretch.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            stats.check_totals('{run_start:  result_ch.best_run_start,
                                 run_length: result_ch.best_run_length,
                                 run_value:  result_ch.best_run_value,
                                 triples:    result_ch.triple_total,
                                 patterns:   result_ch.pattern_total});
        if (hold_results)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("watchdog expired after %0d cycles, %0d results still owed",
                     cycle_count, stats.owed());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one value, idling first at the current rate; returns after transfer.
    task automatic send_value(input bit [SampleW-1:0] v, input bit closes);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.sample_value <= v;
        item_ch.block_end    <= closes;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        stats.note_value(v, closes);
        values_sent++;
    endtask

    // Small alphabet most of the time so runs and pattern pieces line up;
    // the rest walks every bit of the value field.
    function automatic bit [SampleW-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return SampleW'($urandom_range(7));
        else if (sel < 55)
            return $urandom_range(1) ? {SampleW{1'b1}} : '0;
        else if (sel < 65)
            return SampleW'(1) << $urandom_range(SampleW - 1);
        else
            return SampleW'($urandom);
    endfunction

    // A block built from pattern pieces (whole or cut short), equal runs and
    // stray values. Mostly short blocks, now and then up to max_len.
    task automatic send_random_block(input int unsigned max_len);
        int unsigned len;
        int unsigned k;
        int unsigned seg;
        int unsigned n;
        int unsigned j;
        bit [SampleW-1:0] v;
        if (max_len > 12 && $urandom_range(7) == 0)
            len = $urandom_range(max_len, 1);
        else
            len = $urandom_range(max_len > 12 ? 12 : max_len, 1);
        k = 0;
        while (k < len) begin
            seg = $urandom_range(9);
            if (seg < 3) begin
                // pattern piece, truncated about a quarter of the time
                n = ($urandom_range(3) == 0) ? $urandom_range(5, 1) : PatternLen;
                for (j = 0; j < n && k < len; j++) begin
                    send_value(SampleW'(j), k == len - 1);
                    k++;
                end
            end else if (seg < 7) begin
                v = pick_value();
                n = $urandom_range(10, 1);
                for (j = 0; j < n && k < len; j++) begin
                    send_value(v, k == len - 1);
                    k++;
                end
            end else begin
                send_value(pick_value(), k == len - 1);
                k++;
            end
        end
    endtask

    task automatic run_random_phase(input int unsigned goal);
        while (values_sent < goal) send_random_block(200);
    endtask

    // Receiver stalls for a long stretch while tiny blocks keep coming, so the
    // result path backs up into the input.
    task automatic stall_results_while_sending();
        fork
            begin
                hold_results <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_results <= 1'b0;
            end
            repeat (40) send_random_block(3);
        join
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed blocks, sender 23% idle / receiver 45% idle ---
        // single value at the top of the range: run of 1 at position 0
        send_value({SampleW{1'b1}}, 1'b1);
        // exact pattern, closing on its last element
        send_value(0, 1'b0); send_value(1, 1'b0); send_value(2, 1'b0);
        send_value(3, 1'b0); send_value(4, 1'b0); send_value(5, 1'b1);
        // doubled zero restarts the match at one; tied runs keep the earliest
        send_value(0, 1'b0); send_value(0, 1'b0); send_value(1, 1'b0);
        send_value(2, 1'b0); send_value(3, 1'b0); send_value(4, 1'b0);
        send_value(5, 1'b0); send_value(3, 1'b0); send_value(3, 1'b1);
        // five alike: one triple, strictly longer so the global run moves
        repeat (4) send_value(31'h2AAA_AAAA, 1'b0);
        send_value(31'h2AAA_AAAA, 1'b1);

        // --- random phase one, with the long back-pressure stretch ---
        stall_results_while_sending();
        run_random_phase(575);

        // --- random phase two: idle rates swapped ---
        send_idle_pct = 45;
        recv_idle_pct <= 23;
        run_random_phase(1125);

        // --- random phase three: no idling on either side ---
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_phase(1650);

        // drop valid at the edge of the last transfer
        item_ch.valid <= 1'b0;

        while (stats.owed() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        stats.close_out();

        $display("sent %0d values in %0d blocks;",
                 values_sent, stats.blocks_closed);
        $display("checked %0d block totals under three idle mixes and a %0d-cycle stall",
                 stats.totals_checked, HoldCycles);
        if (stats.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d failures", stats.failures);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
